>>> design/assert_macros.svh
// Assertion helpers for the design files; sorted_key_index_top includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// cond must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// cons must hold in the cycle after ante
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst, cond, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

>>> design/ski_pkg.sv
package ski_pkg;

  localparam int CAPACITY  = 256;
  localparam int KEY_BYTES = 8;
  localparam int KEY_W     = 64;
  localparam int LEN_W     = 4;
  localparam int CNT_W     = 9;
  localparam int ADDR_W    = 8;
  localparam int ENTRY_W   = KEY_W + LEN_W;

  typedef enum logic [1:0] {
    ST_PRESENT  = 2'd0,
    ST_MISS     = 2'd1,
    ST_INSERTED = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ORD_LT = 2'd0,
    ORD_EQ = 2'd1,
    ORD_GT = 2'd2
  } ord_t;

  typedef struct packed {
    logic             command;
    logic [KEY_W-1:0] key_bytes;
    logic [LEN_W-1:0] key_length;
  } req_t;

  typedef struct packed {
    status_t          status;
    logic [CNT_W-1:0] slot;
    logic [CNT_W-1:0] entry_count;
  } rsp_t;

  // byte b (counted from the top) is kept when b < len
  function automatic logic [KEY_W-1:0] len_mask(input logic [LEN_W-1:0] len);
    logic [KEY_W-1:0] m;
    m = '0;
    for (int b = 0; b < KEY_BYTES; b++) begin
      if (LEN_W'(b) < len) begin
        m[KEY_W-1-8*b -: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

  // order of stored key a against request key b
  function automatic ord_t key_order(input logic [KEY_W-1:0] a, input logic [LEN_W-1:0] alen,
                                     input logic [KEY_W-1:0] b, input logic [LEN_W-1:0] blen);
    logic [LEN_W-1:0] common;
    logic [KEY_W-1:0] m;
    ord_t             r;
    common = (alen < blen) ? alen : blen;
    m = len_mask(common);
    if ((a & m) < (b & m)) begin
      r = ORD_LT;
    end else if ((a & m) > (b & m)) begin
      r = ORD_GT;
    end else if (alen < blen) begin
      r = ORD_LT;
    end else if (alen > blen) begin
      r = ORD_GT;
    end else begin
      r = ORD_EQ;
    end
    return r;
  endfunction

endpackage

>>> design/ski_ram.sv
module ski_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/sorted_key_index_top.sv
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_ready  ski_pkg::req_t (command, key_bytes, key_length)
// rsp       out        rsp_valid / rsp_ready  ski_pkg::rsp_t (status, slot, entry_count)
//
// Flow: one request at a time, taken in the idle state. The binary search over n keys
//   runs probe by probe (RAM read, then compare), then the response is posted once the
//   response register is free. An insert first shifts the (n - slot) entries at and
//   above the slot up one place: the shift moves one entry per cycle through the
//   single-port-pair key RAM, each entry read and then written in the next cycle.
// Reset: clears the key count and the control state; the key RAM is not cleared,
//   only entries below the count are ever used.
// Stalls: the response register holds a result not yet taken while the next request's
//   search runs; the block waits to post a result until that register is free.
`include "assert_macros.svh"

module sorted_key_index_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  ski_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output ski_pkg::rsp_t rsp
);
  import ski_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_READ   = 5'b00010,
    S_CMP    = 5'b00100,
    S_SHIFT  = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t state;

  // request held for the whole search
  logic             cmd_q;
  logic [KEY_W-1:0] key_q;
  logic [LEN_W-1:0] len_q;

  // search window [lo, hi); eq_q: the entry at hi matched the key
  logic [CNT_W-1:0]  lo;
  logic [CNT_W-1:0]  hi;
  logic              eq_q;
  logic [ADDR_W-1:0] mid_q;
  logic [CNT_W-1:0]  mid;

  logic [CNT_W-1:0] total;
  status_t          st_q;

  // shift sequencer
  logic [CNT_W-1:0]  remain;
  logic [ADDR_W-1:0] sh_idx;
  logic              pend_q;
  logic [ADDR_W-1:0] wr_addr_q;

  // RAM ports
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic [ADDR_W-1:0]  mem_raddr;
  logic [ENTRY_W-1:0] mem_rdata;

  logic [LEN_W-1:0] req_len;
  logic             load;
  ord_t             ord;

  assign req_ready = (state == S_IDLE);
  assign load      = (state == S_FINISH) && (!rsp_valid || rsp_ready);
  assign mid       = lo + ((hi - lo) >> 1);
  assign ord       = key_order(mem_rdata[ENTRY_W-1:LEN_W], mem_rdata[LEN_W-1:0], key_q, len_q);

  // overlong lengths saturate
  assign req_len = (req.key_length > LEN_W'(KEY_BYTES)) ? LEN_W'(KEY_BYTES) : req.key_length;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wr_addr_q;
    mem_wdata = mem_rdata;
    mem_raddr = mid[ADDR_W-1:0];
    case (state)
      S_SHIFT: begin
        mem_raddr = sh_idx;
        mem_we    = pend_q;
      end
      S_FINISH: begin
        mem_we    = load && (st_q == ST_INSERTED);
        mem_waddr = lo[ADDR_W-1:0];
        mem_wdata = {key_q, len_q};
      end
      default: begin
      end
    endcase
  end

  ski_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      total     <= '0;
      pend_q    <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      // a new result posted this cycle keeps valid high
      if (rsp_valid && rsp_ready && !load) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            cmd_q <= req.command;
            len_q <= req_len;
            key_q <= req.key_bytes & len_mask(req_len);
            lo    <= '0;
            hi    <= total;
            eq_q  <= 1'b0;
            state <= S_READ;
          end
        end
        S_READ: begin
          if (lo < hi) begin
            mid_q <= mid[ADDR_W-1:0];
            state <= S_CMP;
          end else if (eq_q) begin
            st_q  <= ST_PRESENT;
            state <= S_FINISH;
          end else if (!cmd_q) begin
            st_q  <= ST_MISS;
            state <= S_FINISH;
          end else if (total == CNT_W'(CAPACITY)) begin
            st_q  <= ST_FULL;
            state <= S_FINISH;
          end else begin
            st_q   <= ST_INSERTED;
            remain <= total - lo;
            sh_idx <= total[ADDR_W-1:0] - ADDR_W'(1);
            pend_q <= 1'b0;
            state  <= S_SHIFT;
          end
        end
        S_CMP: begin
          if (ord == ORD_LT) begin
            lo <= {1'b0, mid_q} + CNT_W'(1);
          end else begin
            hi   <= {1'b0, mid_q};
            eq_q <= (ord == ORD_EQ);
          end
          state <= S_READ;
        end
        S_SHIFT: begin
          // read entry sh_idx now, write it one slot up next cycle
          if (remain != '0) begin
            sh_idx    <= sh_idx - ADDR_W'(1);
            remain    <= remain - CNT_W'(1);
            wr_addr_q <= sh_idx + ADDR_W'(1);
            pend_q    <= 1'b1;
          end else begin
            pend_q <= 1'b0;
            if (!pend_q) begin
              state <= S_FINISH;
            end
          end
        end
        S_FINISH: begin
          if (load) begin
            rsp_valid       <= 1'b1;
            rsp.status      <= st_q;
            rsp.slot        <= lo;
            rsp.entry_count <= (st_q == ST_INSERTED) ? total + CNT_W'(1) : total;
            if (st_q == ST_INSERTED) begin
              total <= total + CNT_W'(1);
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_ALWAYS(a_total_cap, clk, rst, total <= CNT_W'(CAPACITY), "key count above capacity")
  `ASSERT_ALWAYS(a_window, clk, rst, !(state == S_READ || state == S_CMP) || (lo <= hi && hi <= total), "search window out of order")
  `ASSERT_ALWAYS(a_no_search_write, clk, rst, !mem_we || state == S_SHIFT || state == S_FINISH, "RAM written during search")
  `ASSERT_NEXT(a_insert_count, clk, rst, load && st_q == ST_INSERTED, total == $past(total) + CNT_W'(1), "insert did not bump count")
  `ASSERT_NEXT(a_full_no_insert, clk, rst, state == S_READ && total == CNT_W'(CAPACITY), st_q != ST_INSERTED || state == S_CMP, "insert into full table")

endmodule
